### rtl/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

	// sample, error, gain and limit widths, gain fraction bits
	localparam int unsigned SampleW = 16;
	localparam int unsigned ErrW    = 17;
	localparam int unsigned GainW   = 16;
	localparam int unsigned LimitW  = 15;
	localparam int unsigned FracW   = 8;
	// e - e1 and e - 2*e1 + e2
	localparam int unsigned Diff1W  = ErrW + 1;
	localparam int unsigned Diff2W  = ErrW + 2;
	// exact product sum and its shifted form
	localparam int unsigned SumW    = GainW + Diff2W + 3;
	localparam int unsigned ResW    = SumW - FracW;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [LimitW-1:0] LimitReset = LimitW'(100);

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_SETPOINT   = 3'd0,
		REG_GAIN_PROP  = 3'd1,
		REG_GAIN_INTEG = 3'd2,
		REG_GAIN_DERIV = 3'd3,
		REG_DEAD_BAND  = 3'd4,
		REG_OUT_LIMIT  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SampleW-1:0] setpoint;
		logic signed [GainW-1:0]   gain_prop;
		logic signed [GainW-1:0]   gain_integ;
		logic signed [GainW-1:0]   gain_deriv;
		logic [SampleW-1:0]        dead_band;
		logic [LimitW-1:0]         out_limit;
	} cfg_t;

	// error history held between samples
	typedef struct packed {
		logic signed [ErrW-1:0] err_prev;
		logic signed [ErrW-1:0] err_prev2;
		logic                   pending;
	} hist_t;

	typedef struct packed {
		logic signed [SampleW-1:0] drive_delta;
		logic signed [ErrW-1:0]    err;
	} calc_res_t;

endpackage

`default_nettype wire

### rtl/ipid_calc.sv
`default_nettype none

module ipid_calc import ipid_pkg::*; (
	input  cfg_t                      cfg,
	input  hist_t                     hist,
	input  logic signed [SampleW-1:0] measure,
	input  logic                      restart,
	output calc_res_t                 res
);

	logic signed [ErrW-1:0]   err_raw;
	logic [ErrW-1:0]          err_mag;
	logic signed [ErrW-1:0]   err;
	logic signed [ErrW-1:0]   e1;
	logic signed [ErrW-1:0]   e2;
	logic signed [Diff1W-1:0] diff1;
	logic signed [Diff2W-1:0] diff2;
	logic signed [SumW-1:0]   prod_p;
	logic signed [SumW-1:0]   prod_i;
	logic signed [SumW-1:0]   prod_d;
	logic signed [SumW-1:0]   sum;
	logic signed [ResW-1:0]   shifted;
	logic signed [ResW-1:0]   lim_pos;
	logic signed [ResW-1:0]   lim_neg;
	logic signed [ResW-1:0]   clamped;

	// form the error and suppress it inside the dead band
	always_comb begin
		err_raw = ErrW'(cfg.setpoint) - ErrW'(measure);
		err_mag = err_raw[ErrW-1] ? ErrW'(-err_raw) : err_raw;
		if (err_mag < {1'b0, cfg.dead_band}) begin
			err = '0;
		end else begin
			err = err_raw;
		end
	end

	// seed the history on the first sample after reset or a restart
	always_comb begin
		if (restart || hist.pending) begin
			e1 = err;
			e2 = err;
		end else begin
			e1 = hist.err_prev;
			e2 = hist.err_prev2;
		end
	end

	// velocity-form terms, exact sum, floor shift by the gain fraction
	always_comb begin
		diff1   = Diff1W'(err) - Diff1W'(e1);
		diff2   = Diff2W'(err) - (Diff2W'(e1) <<< 1) + Diff2W'(e2);
		prod_p  = SumW'(cfg.gain_prop) * SumW'(diff1);
		prod_i  = SumW'(cfg.gain_integ) * SumW'(err);
		prod_d  = SumW'(cfg.gain_deriv) * SumW'(diff2);
		sum     = prod_p + prod_i + prod_d;
		shifted = ResW'(sum >>> FracW);
	end

	// clamp to the symmetric limit
	always_comb begin
		lim_pos = ResW'({1'b0, cfg.out_limit});
		lim_neg = -lim_pos;
		if (shifted > lim_pos) begin
			clamped = lim_pos;
		end else if (shifted < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = shifted;
		end
		res.drive_delta = clamped[SampleW-1:0];
		res.err         = err;
	end

endmodule

`default_nettype wire

### rtl/incremental_pid_deadzone_clamp_top.sv
// Incremental PID with dead band and output clamp.
//
// Input channel: measure and restart under in_valid / in_ready. Output channel:
// drive_delta under out_valid / out_ready, one result per input sample, in order.
// Configuration: a write at cfg_we with cfg_index selecting setpoint, the three
// Q8.8 gains, dead band or output limit; writes take effect at once. Writes are
// to be made only while no sample is in flight; the block does not enforce this.
//
// A sample is registered on acceptance, goes through combinational logic (error,
// dead band, three products, shift and clamp) and lands in the result register,
// which raises out_valid when it is loaded. A new sample is taken every cycle
// while the receiver keeps up; the rate is set by the error history loop.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample before in_ready drops.
//
// Reset clears the configuration to its defaults (limit 100, all else zero),
// empties both registers and arms seeding of the error history.
`default_nettype none

module incremental_pid_deadzone_clamp_top import ipid_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [SampleW-1:0] measure,
	input  wire logic                      restart,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [SampleW-1:0]      drive_delta,
	input  wire logic                      cfg_we,
	input  wire logic [CfgIdxW-1:0]        cfg_index,
	input  wire logic [CfgDataW-1:0]       cfg_data
);

	cfg_t                      cfg_q;
	hist_t                     hist_q;
	logic                      valid_s1;
	logic signed [SampleW-1:0] measure_s1;
	logic                      restart_s1;
	logic                      advance;
	calc_res_t                 calc;
	logic signed [SampleW-1:0] delta_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint   <= '0;
			cfg_q.gain_prop  <= '0;
			cfg_q.gain_integ <= '0;
			cfg_q.gain_deriv <= '0;
			cfg_q.dead_band  <= '0;
			cfg_q.out_limit  <= LimitReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SETPOINT:   cfg_q.setpoint   <= cfg_data;
				REG_GAIN_PROP:  cfg_q.gain_prop  <= cfg_data;
				REG_GAIN_INTEG: cfg_q.gain_integ <= cfg_data;
				REG_GAIN_DERIV: cfg_q.gain_deriv <= cfg_data;
				REG_DEAD_BAND:  cfg_q.dead_band  <= cfg_data;
				REG_OUT_LIMIT:  cfg_q.out_limit  <= cfg_data[LimitW-1:0];
				default: ;
			endcase
		end
	end

	// advance the sample when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			measure_s1 <= measure;
			restart_s1 <= restart;
		end
	end

	ipid_calc u_calc (
		.cfg     (cfg_q),
		.hist    (hist_q),
		.measure (measure_s1),
		.restart (restart_s1),
		.res     (calc)
	);

	// shift the error history as each sample completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q.err_prev  <= '0;
			hist_q.err_prev2 <= '0;
			hist_q.pending   <= 1'b1;
		end else if (advance) begin
			hist_q.err_prev2 <= (restart_s1 || hist_q.pending) ? calc.err : hist_q.err_prev;
			hist_q.err_prev  <= calc.err;
			hist_q.pending   <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			delta_q <= calc.drive_delta;
		end
	end

	assign drive_delta = delta_q;

endmodule

`default_nettype wire
